/* rtl/fte_pkg.sv */
// Shared types, constants and helpers for the face texture extents block.
`timescale 1ns / 1ps

package fte_pkg;

  // Texels per texture block. It must be a power of two: the block index is
  // taken with an arithmetic shift.
  localparam int TEX_STEP   = 16;
  localparam int DIV_SHIFT  = $clog2(TEX_STEP * 256);
  localparam int SPAN_LIMIT = 4096;
  // span * TEX_STEP > SPAN_LIMIT is the same test as span > SPAN_MAX.
  localparam int SPAN_MAX   = SPAN_LIMIT / TEX_STEP;

  localparam int VAL_W  = 32;
  localparam int PROD_W = 64;
  localparam int BLK_W  = 21;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_S_AXIS_X = 3'd0,
    REG_S_AXIS_Y = 3'd1,
    REG_S_AXIS_Z = 3'd2,
    REG_S_SHIFT  = 3'd3,
    REG_T_AXIS_X = 3'd4,
    REG_T_AXIS_Y = 3'd5,
    REG_T_AXIS_Z = 3'd6,
    REG_T_SHIFT  = 3'd7
  } fte_reg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] ax;
    logic signed [VAL_W-1:0] ay;
    logic signed [VAL_W-1:0] az;
    logic signed [VAL_W-1:0] shift;
  } fte_axis_t;

  typedef struct packed {
    fte_axis_t s;
    fte_axis_t t;
  } fte_cfg_t;

  // Load strobes for the product and projection registers.
  typedef struct packed {
    logic ld_prod;
    logic ld_proj;
  } fte_proj_ctl_t;

  // Tracker update: a projection moves in, possibly closing the face.
  typedef struct packed {
    logic upd;
    logic last;
    logic special;
  } fte_trk_ctl_t;

  typedef struct packed {
    logic signed [BLK_W-1:0] bmin;
    logic signed [BLK_W-1:0] bmax;
    logic                    ok;
  } fte_ext_t;

  // Clamp a 34-bit block index into the output range.
  function automatic logic signed [BLK_W-1:0] sat_blk(input logic signed [33:0] v);
    logic signed [33:0] hi_lim;
    logic signed [33:0] lo_lim;
    hi_lim = 34'sd1048575;
    lo_lim = -34'sd1048576;
    if (v > hi_lim) begin
      return {1'b0, {(BLK_W-1){1'b1}}};
    end else if (v < lo_lim) begin
      return {1'b1, {(BLK_W-1){1'b0}}};
    end else begin
      return v[BLK_W-1:0];
    end
  endfunction

endpackage

/* rtl/fte_cfg.sv */
// Configuration register file for the texture axes and offsets.
`timescale 1ns / 1ps

module fte_cfg
  import fte_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  output fte_cfg_t             cfg
);

  fte_cfg_t cfg_next;
  logic     wr;

  assign wr = cfg_valid;

  always_comb begin
    cfg_next = cfg;
    if (wr) begin
      unique case (fte_reg_t'(cfg_index))
        REG_S_AXIS_X: cfg_next.s.ax    = cfg_data;
        REG_S_AXIS_Y: cfg_next.s.ay    = cfg_data;
        REG_S_AXIS_Z: cfg_next.s.az    = cfg_data;
        REG_S_SHIFT:  cfg_next.s.shift = cfg_data;
        REG_T_AXIS_X: cfg_next.t.ax    = cfg_data;
        REG_T_AXIS_Y: cfg_next.t.ay    = cfg_data;
        REG_T_AXIS_Z: cfg_next.t.az    = cfg_data;
        REG_T_SHIFT:  cfg_next.t.shift = cfg_data;
        default:      cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

/* rtl/fte_project.sv */
// Projection of a vertex onto one texture axis: products, then sum, floor, offset.
`timescale 1ns / 1ps

module fte_project
  import fte_pkg::*;
(
  input  logic                    clk,
  input  fte_proj_ctl_t           ctl,
  input  logic signed [VAL_W-1:0] vx,
  input  logic signed [VAL_W-1:0] vy,
  input  logic signed [VAL_W-1:0] vz,
  input  fte_axis_t               axis,
  output logic signed [VAL_W-1:0] proj
);

  logic signed [PROD_W-1:0] px;
  logic signed [PROD_W-1:0] py;
  logic signed [PROD_W-1:0] pz;
  logic signed [PROD_W+1:0] sum;
  logic signed [PROD_W-23:0] fl;
  logic signed [PROD_W-22:0] tot;
  logic signed [VAL_W-1:0]  proj_next;

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      px <= vx * axis.ax;
      py <= vy * axis.ay;
      pz <= vz * axis.az;
    end
  end

  // Q24.8 times Q8.24 is Q32.32 in texels; dropping 24 bits of the exact sum
  // is a floor back to Q24.8.
  assign sum = {{2{px[PROD_W-1]}}, px} + {{2{py[PROD_W-1]}}, py}
             + {{2{pz[PROD_W-1]}}, pz};
  assign fl  = sum[PROD_W+1:24];
  assign tot = {fl[PROD_W-23], fl}
             + {{(PROD_W-21-VAL_W){axis.shift[VAL_W-1]}}, axis.shift};

  always_comb begin
    if (tot > $signed({{(PROD_W-21-VAL_W){1'b0}}, VAL_MAX})) begin
      proj_next = VAL_MAX;
    end else if (tot < $signed({{(PROD_W-21-VAL_W){1'b1}}, VAL_MIN})) begin
      proj_next = VAL_MIN;
    end else begin
      proj_next = tot[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_proj) begin
      proj <= proj_next;
    end
  end

endmodule

/* rtl/fte_track.sv */
// Running minimum and maximum of one axis, and its block extents at face end.
`timescale 1ns / 1ps

module fte_track
  import fte_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  fte_trk_ctl_t            ctl,
  input  logic signed [VAL_W-1:0] proj,
  output fte_ext_t                ext
);

  logic signed [VAL_W-1:0] run_min;
  logic signed [VAL_W-1:0] run_max;
  logic signed [VAL_W-1:0] run_min_next;
  logic signed [VAL_W-1:0] run_max_next;
  logic signed [VAL_W-1:0] fin_min;
  logic signed [VAL_W-1:0] fin_max;
  logic                    fin_special;

  logic signed [VAL_W:0]   max_up;
  logic signed [33:0]      lo;
  logic signed [33:0]      hi;
  logic signed [33:0]      span;
  logic                    bad;

  assign run_min_next = (proj < run_min) ? proj : run_min;
  assign run_max_next = (proj > run_max) ? proj : run_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min <= VAL_MAX;
      run_max <= VAL_MIN;
    end else if (ctl.upd) begin
      if (ctl.last) begin
        run_min <= VAL_MAX;
        run_max <= VAL_MIN;
      end else begin
        run_min <= run_min_next;
        run_max <= run_max_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd && ctl.last) begin
      fin_min     <= run_min_next;
      fin_max     <= run_max_next;
      fin_special <= ctl.special;
    end
  end

  // Floor of the minimum and ceiling of the maximum, in blocks.
  assign max_up = {fin_max[VAL_W-1], fin_max} + (VAL_W+1)'((1 << DIV_SHIFT) - 1);
  assign lo     = 34'(fin_min >>> DIV_SHIFT);
  assign hi     = 34'(max_up >>> DIV_SHIFT);
  assign span   = hi - lo;
  assign bad    = (!fin_special && span > 34'(SPAN_MAX)) || span < 34'sd0;

  always_comb begin
    ext.ok = !bad;
    if (bad) begin
      ext.bmin = '0;
      ext.bmax = BLK_W'(1);
    end else begin
      ext.bmin = sat_blk(lo);
      ext.bmax = sat_blk(hi);
    end
  end

  a_clear_after_face: assert property (@(posedge clk) disable iff (rst)
    ctl.upd && ctl.last |=> run_min == VAL_MAX && run_max == VAL_MIN)
    else $error("trackers not cleared after the last vertex of a face");

endmodule

/* rtl/face_texture_extents_top.sv */
// Top level of the face texture extents block: vertex pipeline and result register.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  vertex_x/y/z, special_texture, last_vertex
//   out      output     out_valid/out_stall min/max_s_block, min/max_t_block, extents_ok
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One vertex is taken per cycle while in_stall is low. A vertex passes an input
// register, the product registers and the projection registers; the tracker update
// and a face's result register follow; out_valid rises as the result register loads.
// Reset clears the stage valid bits, the trackers and the configuration.
// A waiting result holds the pipeline back only once another last vertex reaches
// the tracker stage; until then vertices keep flowing. cfg_ready is always high.
`timescale 1ns / 1ps

module face_texture_extents_top
  import fte_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [VAL_W-1:0] vertex_x,
  input  logic signed [VAL_W-1:0] vertex_y,
  input  logic signed [VAL_W-1:0] vertex_z,
  input  logic                    special_texture,
  input  logic                    last_vertex,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [BLK_W-1:0] min_s_block,
  output logic signed [BLK_W-1:0] max_s_block,
  output logic signed [BLK_W-1:0] min_t_block,
  output logic signed [BLK_W-1:0] max_t_block,
  output logic                    extents_ok,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [VAL_W-1:0]        cfg_data
);

  fte_cfg_t      cfg;
  fte_proj_ctl_t pctl;
  fte_trk_ctl_t  tctl;
  fte_ext_t      ext_s;
  fte_ext_t      ext_t;

  logic v1, v2, v3, v4;
  logic last1, last2, last3;
  logic spec1, spec2, spec3;
  logic signed [VAL_W-1:0] x1, y1, z1;
  logic signed [VAL_W-1:0] proj_s, proj_t;

  logic acc, adv1, adv2, adv3, ld5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign cfg_ready = 1'b1;

  fte_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Ready chain from the result register back to the input.
  assign rdy5 = !out_valid || !out_stall;
  assign ld5  = v4 && rdy5;
  assign rdy4 = !v4 || rdy5;
  assign adv3 = v3 && (!last3 || rdy4);
  assign rdy3 = !v3 || adv3;
  assign adv2 = v2 && rdy3;
  assign rdy2 = !v2 || rdy3;
  assign adv1 = v1 && rdy2;
  assign rdy1 = !v1 || rdy2;
  assign acc  = in_valid && rdy1;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= acc  || (v1 && !rdy2);
      v2        <= adv1 || (v2 && !rdy3);
      v3        <= adv2 || (v3 && !adv3);
      v4        <= (adv3 && last3) || (v4 && !rdy5);
      out_valid <= ld5  || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      x1    <= vertex_x;
      y1    <= vertex_y;
      z1    <= vertex_z;
      last1 <= last_vertex;
      spec1 <= special_texture;
    end
    if (adv1) begin
      last2 <= last1;
      spec2 <= spec1;
    end
    if (adv2) begin
      last3 <= last2;
      spec3 <= spec2;
    end
  end

  assign pctl.ld_prod = adv1;
  assign pctl.ld_proj = adv2;

  fte_project u_proj_s (
    .clk  (clk),
    .ctl  (pctl),
    .vx   (x1),
    .vy   (y1),
    .vz   (z1),
    .axis (cfg.s),
    .proj (proj_s)
  );

  fte_project u_proj_t (
    .clk  (clk),
    .ctl  (pctl),
    .vx   (x1),
    .vy   (y1),
    .vz   (z1),
    .axis (cfg.t),
    .proj (proj_t)
  );

  assign tctl.upd     = adv3;
  assign tctl.last    = last3;
  assign tctl.special = spec3;

  fte_track u_trk_s (
    .clk  (clk),
    .rst  (rst),
    .ctl  (tctl),
    .proj (proj_s),
    .ext  (ext_s)
  );

  fte_track u_trk_t (
    .clk  (clk),
    .rst  (rst),
    .ctl  (tctl),
    .proj (proj_t),
    .ext  (ext_t)
  );

  always_ff @(posedge clk) begin
    if (ld5) begin
      min_s_block <= ext_s.bmin;
      max_s_block <= ext_s.bmax;
      min_t_block <= ext_t.bmin;
      max_t_block <= ext_t.bmax;
      extents_ok  <= ext_s.ok && ext_t.ok;
    end
  end

  a_stall_needs_full_input: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1)
    else $error("input stalled with an empty input register");

  a_last_reaches_result: assert property (@(posedge clk) disable iff (rst)
    adv3 && last3 |=> v4)
    else $error("last vertex of a face did not reach the result stage");

  a_extents_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> min_s_block <= max_s_block && min_t_block <= max_t_block)
    else $error("block minimum above block maximum");

  a_bad_forced: assert property (@(posedge clk) disable iff (rst)
    out_valid && !extents_ok |->
      (min_s_block == '0 && max_s_block == BLK_W'(1)) ||
      (min_t_block == '0 && max_t_block == BLK_W'(1)))
    else $error("bad extents without an axis forced to zero to one");

endmodule
